>>> sv/top_k_ranked_table_top_assert.svh
// assertion macros shared by the checker
`ifndef TOP_K_RANKED_TABLE_TOP_ASSERT_SVH
`define TOP_K_RANKED_TABLE_TOP_ASSERT_SVH

// implication checked on every clock edge outside reset
`define TKR_ASSERT_IMPL(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("%m: check failed");

// implication whose consequent is checked on the next clock edge
`define TKR_ASSERT_NEXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("%m: check failed");

`endif

>>> sv/tkrt_pkg.sv
// -----------------------------------------------------------------------------
// tkrt_pkg
// shared widths and record type of the ranked table
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tkrt_pkg;
  localparam int ScoreW  = 31;
  localparam int LinesW  = 16;
  localparam int PiecesW = 24;
  localparam int StampW  = 47;
  localparam int RankW   = 4;
  localparam int HeldW   = 5;
  localparam int RecW    = ScoreW + LinesW + PiecesW + StampW;

  localparam logic ReqInsert = 1'b0;
  localparam logic ReqPurge  = 1'b1;

  typedef struct packed {
    logic [StampW-1:0]  stamp;
    logic [PiecesW-1:0] pieces;
    logic [LinesW-1:0]  lines;
    logic [ScoreW-1:0]  score;
  } rec_t;
endpackage

>>> sv/tkrt_ram.sv
// -----------------------------------------------------------------------------
// tkrt_ram
// record store, one write and one registered read port
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tkrt_ram #(
  parameter int Depth = 16,
  parameter int AddrW = 4
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AddrW-1:0]    waddr,
  input  tkrt_pkg::rec_t      wdata,
  input  logic [AddrW-1:0]    raddr,
  output tkrt_pkg::rec_t      rdata
);
  tkrt_pkg::rec_t mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/top_k_ranked_table_top.sv
// -----------------------------------------------------------------------------
// top_k_ranked_table_top
// sorted table of the best records with insert and purge by timestamp
// -----------------------------------------------------------------------------
// The table lives in one memory with a registered read port. A request walks
// it one entry at a time: a read state, then a state that acts on
// the data. An insert reads entries from the last valid one down, moving each
// one place back while the new record still ranks before it, and writes the
// record in the hole. It then goes on down through entries with the same
// score, lines and stamp, so that an identical earlier copy can report its own
// position as the rank. A purge reads entries from the front and writes back
// the ones it keeps at a trailing write pointer. An insert into the empty
// table reads nothing, and a rejected insert reads only the tail entry. One
// word is handled at a time. The result waits in an output register, and the
// block is ready for the next word as soon as the result is raised, even
// while that result waits. A finished walk holds until the output register is
// empty.
`timescale 1ns / 1ps

module top_k_ranked_table_top #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // score, lines_cleared, pieces_placed, stamp, cutoff_stamp (lsb first)
  input  logic [167:0] s_tdata,
  // req_type
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // accepted, rank, entries_held (lsb first)
  output logic [15:0]  m_tdata
);
  localparam int AddrW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CntW  = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [2:0] {
    IDLE, INS_READ, INS_STEP, DUP_READ, DUP_STEP, PUR_READ, PUR_STEP, FINISH
  } state_t;

  state_t              state;
  tkrt_pkg::rec_t      rec;
  logic [tkrt_pkg::StampW-1:0] cut;
  logic [CntW-1:0]     fill;
  logic [CntW-1:0]     rptr;      // entry being read
  logic [CntW-1:0]     wptr;      // write pointer (purge)
  logic [CntW-1:0]     last;      // highest slot an insert fills
  logic [CntW-1:0]     tail_score_idx;
  logic                acc;
  logic [CntW-1:0]     rank_out;

  logic                we;
  logic [AddrW-1:0]    waddr;
  tkrt_pkg::rec_t      wdata;
  logic [AddrW-1:0]    raddr;
  tkrt_pkg::rec_t      rdata;

  function automatic logic [tkrt_pkg::HeldW-1:0] HeldOut(input logic [CntW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[tkrt_pkg::HeldW-1:0];
  endfunction

  function automatic logic [tkrt_pkg::RankW-1:0] RankOut(
    input logic a, input logic d, input logic [CntW-1:0] di, input logic [CntW-1:0] r
  );
    logic [31:0] w;
    w = d ? 32'(di) : 32'(r);
    return a ? w[tkrt_pkg::RankW-1:0] : '0;
  endfunction

  tkrt_ram #(.Depth(MAX_ENTRIES), .AddrW(AddrW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  // new record ranks strictly before the entry just read
  logic ahead;
  logic same;
  logic key_eq;
  always_comb begin
    if (rec.score != rdata.score) begin
      ahead = rec.score > rdata.score;
    end else if (rec.lines != rdata.lines) begin
      ahead = rec.lines > rdata.lines;
    end else begin
      ahead = rec.stamp < rdata.stamp;
    end
    same   = (rdata == rec);
    // same sort key: an identical copy can only sit in such a run
    key_eq = (rec.score == rdata.score) && (rec.lines == rdata.lines)
             && (rec.stamp == rdata.stamp);
  end

  assign s_tready = (state == IDLE);
  assign tail_score_idx = fill - CntW'(1);

  // first read of a full table is the tail: score must beat it
  logic reject;
  assign reject = (rptr == tail_score_idx) && (fill == CntW'(MAX_ENTRIES))
                  && !(rec.score > rdata.score);

  // rank of an identical earlier copy: tracked during the walk
  logic [CntW-1:0] dup_idx;
  logic            dup_hit;

  always_comb begin
    we    = 1'b0;
    waddr = AddrW'(0);
    wdata = rdata;
    raddr = rptr[AddrW-1:0];
    unique case (state)
      INS_STEP: begin
        if (!reject) begin
          if (ahead) begin
            we    = (rptr + CntW'(1)) <= last;
            waddr = AddrW'(rptr + CntW'(1));
          end else begin
            we    = 1'b1;
            waddr = AddrW'(rptr + CntW'(1));
            wdata = rec;
          end
        end
      end
      PUR_STEP: begin
        we    = rdata.stamp >= cut;
        waddr = wptr[AddrW-1:0];
      end
      FINISH: begin
        we    = (state == FINISH) && acc && (rank_out == '0) && !dup_hit;
        waddr = AddrW'(0);
        wdata = rec;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      fill     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (s_tvalid && s_tready) begin
            rec.score  <= s_tdata[30:0];
            rec.lines  <= s_tdata[46:31];
            rec.pieces <= s_tdata[70:47];
            rec.stamp  <= s_tdata[117:71];
            cut        <= s_tdata[164:118];
            acc        <= 1'b0;
            rank_out   <= '0;
            dup_hit    <= 1'b0;
            if (s_tuser == tkrt_pkg::ReqPurge) begin
              rptr  <= '0;
              wptr  <= '0;
              state <= PUR_READ;
            end else if (fill == '0) begin
              // empty: record lands at slot 0
              acc      <= 1'b1;
              state    <= FINISH;
              fill     <= fill + CntW'(1);
            end else begin
              rptr  <= tail_score_idx;
              last  <= (fill < CntW'(MAX_ENTRIES)) ? fill : CntW'(MAX_ENTRIES - 1);
              state <= INS_READ;
            end
          end
        end
        INS_READ: begin
          state <= INS_STEP;
        end
        INS_STEP: begin
          if (reject) begin
            state <= FINISH;
          end else begin
            acc <= 1'b1;
            if (same) begin
              dup_hit <= 1'b1;
              dup_idx <= rptr;
            end
            if (ahead && rptr != '0) begin
              rptr  <= rptr - CntW'(1);
              state <= INS_READ;
            end else begin
              rank_out <= ahead ? '0 : rptr + CntW'(1);
              if (fill < CntW'(MAX_ENTRIES)) fill <= fill + CntW'(1);
              // look further down for an identical copy among equal keys
              if (!ahead && key_eq && rptr != '0) begin
                rptr  <= rptr - CntW'(1);
                state <= DUP_READ;
              end else begin
                state <= FINISH;
              end
            end
          end
        end
        DUP_READ: begin
          state <= DUP_STEP;
        end
        DUP_STEP: begin
          if (same) begin
            dup_hit <= 1'b1;
            dup_idx <= rptr;
          end
          if (key_eq && rptr != '0) begin
            rptr  <= rptr - CntW'(1);
            state <= DUP_READ;
          end else begin
            state <= FINISH;
          end
        end
        PUR_READ: begin
          if (rptr >= fill) begin
            fill  <= wptr;
            state <= FINISH;
          end else begin
            state <= PUR_STEP;
          end
        end
        PUR_STEP: begin
          if (rdata.stamp >= cut) wptr <= wptr + CntW'(1);
          rptr  <= rptr + CntW'(1);
          state <= PUR_READ;
        end
        FINISH: begin
          if (!m_tvalid) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, HeldOut(fill), RankOut(acc, dup_hit, dup_idx, rank_out),
                         acc};
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

>>> sv/tkrt_checker.sv
// -----------------------------------------------------------------------------
// tkrt_checker
// port-level checks of the ranked table
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "top_k_ranked_table_top_assert.svh"

module tkrt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);
  `TKR_ASSERT_IMPL(a_rank_zero, m_tvalid && !m_tdata[0], m_tdata[4:1] == 4'd0)
  `TKR_ASSERT_NEXT(a_take_busy, s_tvalid && s_tready, !s_tready)
  `TKR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `TKR_ASSERT_IMPL(a_pad_zero, m_tvalid, m_tdata[15:10] == 6'd0)
endmodule

bind top_k_ranked_table_top tkrt_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

>>> tb/top_k_ranked_table_top_tb.sv
// -----------------------------------------------------------------------------
// top_k_ranked_table_top_tb
// self-checking bench for the ranked table of best records
// -----------------------------------------------------------------------------
// A short table of directed words runs first, then about 1250 random words.
// Random inserts draw keys from small pools so that ties and duplicates are
// common. Purges mostly use cutoffs picked from held stamps. Each result
// word is compared with the oldest prediction. Both sides idle at random, one
// long receiver hold-off fills the block, and one sender pause drains it.
`timescale 1ns / 1ps

module top_k_ranked_table_top_tb;

  localparam int Depth   = 16;
  localparam int NumRand = 1250;

  // one result word as predicted or observed
  typedef struct packed {
    logic [tkrt_pkg::HeldW-1:0] held;
    logic [tkrt_pkg::RankW-1:0] rank;
    logic                       acc;
  } outcome_t;

  // one directed row; chk says the typed outcome is also compared
  typedef struct {
    logic                        req;
    tkrt_pkg::rec_t              rec;
    logic [tkrt_pkg::StampW-1:0] cut;
    bit                          chk;
    outcome_t                    want;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [167:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [15:0]  m_tdata;

  // predictor copy of the table
  tkrt_pkg::rec_t tbl [Depth];
  int             fill;
  outcome_t       pending_results [$];
  outcome_t       typed_results [$];
  bit             typed_flags [$];
  int             errors = 0;
  bit             stall_long = 1'b0;
  bit             drive_done = 1'b0;

  always #5 clk = ~clk;

  top_k_ranked_table_top #(.MAX_ENTRIES(Depth)) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  // true when the new record sorts strictly ahead of held entry i
  function automatic bit sorts_ahead(tkrt_pkg::rec_t r, int i);
    if (r.score != tbl[i].score) return r.score > tbl[i].score;
    if (r.lines != tbl[i].lines) return r.lines > tbl[i].lines;
    return r.stamp < tbl[i].stamp;
  endfunction

  function automatic outcome_t table_update(logic req, tkrt_pkg::rec_t r,
                                            logic [tkrt_pkg::StampW-1:0] cut);
    outcome_t o;
    int pos;
    int w;
    bit take;
    o = '0;
    if (req == tkrt_pkg::ReqInsert) begin
      take = (fill < Depth) || (r.score > tbl[fill-1].score);
      if (take) begin
        pos = 0;
        while (pos < fill && !sorts_ahead(r, pos)) pos++;
        for (int i = (fill < Depth) ? fill : Depth - 1; i > pos; i--) tbl[i] = tbl[i-1];
        tbl[pos] = r;
        if (fill < Depth) fill++;
        o.acc  = 1'b1;
        o.rank = pos[tkrt_pkg::RankW-1:0];
        // an identical earlier record reports its own position
        for (int i = 0; i < pos; i++) begin
          if (tbl[i] == r) begin
            o.rank = i[tkrt_pkg::RankW-1:0];
            break;
          end
        end
      end
    end else begin
      w = 0;
      for (int i = 0; i < fill; i++) begin
        if (tbl[i].stamp >= cut) begin
          tbl[w] = tbl[i];
          w++;
        end
      end
      fill = w;
    end
    o.held = fill[tkrt_pkg::HeldW-1:0];
    return o;
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // offer one word and wait until it is taken; predict on acceptance
  task automatic send_word(logic req, tkrt_pkg::rec_t r, logic [tkrt_pkg::StampW-1:0] cut,
                           bit chk, outcome_t want);
    outcome_t o;
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= 168'({cut, r.stamp, r.pieces, r.lines, r.score});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    o = table_update(req, r, cut);
    pending_results.push_back(o);
    typed_results.push_back(want);
    typed_flags.push_back(chk);
  endtask

  task automatic idle_sender(int n);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic tkrt_pkg::rec_t rand_rec();
    tkrt_pkg::rec_t r;
    int k;
    k = $urandom_range(0, 9);
    // small pools make ties likely, full range covers every bit
    r.score  = (k < 6) ? 31'($urandom_range(0, 7) * 1000) : 31'({$urandom, $urandom});
    r.lines  = (k < 7) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    r.pieces = (k < 7) ? 24'($urandom_range(0, 1)) : 24'($urandom);
    r.stamp  = (k < 7) ? 47'd20240101000000 + 47'($urandom_range(0, 5))
                       : 47'({$urandom, $urandom});
    return r;
  endfunction

  // result side: random stall, one long hold-off, field compare
  initial begin : receiver
    outcome_t got;
    outcome_t exp_o;
    outcome_t typed;
    bit       tchk;
    int       g;
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (stall_long) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        stall_long = 1'b0;
      end
      g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      if (g > 0) begin
        m_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      got = m_tdata[9:0];
      m_tready <= 1'b0;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        errors++;
      end else begin
        exp_o = pending_results.pop_front();
        typed = typed_results.pop_front();
        tchk  = typed_flags.pop_front();
        if (got.acc !== exp_o.acc || got.rank !== exp_o.rank || got.held !== exp_o.held) begin
          $display({"%0t: mismatch expected acc=%0d rank=%0d held=%0d",
                    " actual acc=%0d rank=%0d held=%0d"},
                   $time, exp_o.acc, exp_o.rank, exp_o.held, got.acc, got.rank, got.held);
          errors++;
        end
        if (tchk && got !== typed) begin
          $display("%0t: directed mismatch expected %h actual %h", $time, typed, got);
          errors++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #20ms;
    $display("** top_k_ranked_table_top: FAILED **");
    $finish;
  end

  initial begin : sender
    row_t  rows [$];
    row_t  rw;
    tkrt_pkg::rec_t r;
    tkrt_pkg::rec_t z;
    logic [tkrt_pkg::StampW-1:0] c;
    int    wait_cnt;
    fill = 0;
    z = '0;
    // directed rows: purge of empty table, extremes, ties, duplicates, overflow
    rw = '{tkrt_pkg::ReqPurge, z, '1, 1'b1, '{held: 5'd0, rank: 4'd0, acc: 1'b0}};
    rows.push_back(rw);
    rw = '{tkrt_pkg::ReqInsert, z, '0, 1'b1, '{held: 5'd1, rank: 4'd0, acc: 1'b1}};
    rows.push_back(rw);
    r = '{stamp: '1, pieces: '1, lines: '1, score: '1};
    rw = '{tkrt_pkg::ReqInsert, r, '1, 1'b1, '{held: 5'd2, rank: 4'd0, acc: 1'b1}};
    rows.push_back(rw);
    rw = '{tkrt_pkg::ReqInsert, r, '0, 1'b1, '{held: 5'd3, rank: 4'd0, acc: 1'b1}};
    rows.push_back(rw);
    for (int i = 0; i < 16; i++) begin
      r = '{stamp: 47'd20240101000000 + 47'(i % 3), pieces: 24'(i), lines: 16'(i % 2),
            score: 31'(500 + (i % 4))};
      rw = '{tkrt_pkg::ReqInsert, r, '0, 1'b0, '0}; rows.push_back(rw);
    end
    // full table: score below the last is rejected
    r = '{stamp: 47'd1, pieces: '0, lines: '1, score: 31'd0};
    rw = '{tkrt_pkg::ReqInsert, r, '0, 1'b1, '{held: 5'd16, rank: 4'd0, acc: 1'b0}};
    rows.push_back(rw);
    rw = '{tkrt_pkg::ReqPurge, z, 47'd20240101000001, 1'b0, '0}; rows.push_back(rw);
    rw = '{tkrt_pkg::ReqPurge, z, 47'd0, 1'b0, '0}; rows.push_back(rw);
    rw = '{tkrt_pkg::ReqPurge, z, 47'h7FFF_FFFF_FFFF, 1'b0, '0}; rows.push_back(rw);
    // only the two all-ones records hold the top stamp
    rw = '{tkrt_pkg::ReqPurge, z, '1, 1'b1, '{held: 5'd2, rank: 4'd0, acc: 1'b0}};
    rows.push_back(rw);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      send_word(rows[i].req, rows[i].rec, rows[i].cut, rows[i].chk, rows[i].want);
      idle_sender(gap_len());
    end
    for (int n = 0; n < NumRand; n++) begin
      if (n == 300) stall_long = 1'b1;
      if (n == 700 && pending_results.size() != 0) begin
        // pause until every word has come back
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 11) == 0) begin
        c = (fill > 0 && $urandom_range(0, 3) != 0) ? tbl[$urandom_range(0, fill-1)].stamp
                                                    : 47'({$urandom, $urandom});
        r = rand_rec();
        send_word(tkrt_pkg::ReqPurge, r, c, 1'b0, '0);
      end else begin
        r = rand_rec();
        send_word(tkrt_pkg::ReqInsert, r, 47'({$urandom, $urandom}), 1'b0, '0);
      end
      if (n % 200 < 150) idle_sender(gap_len());
    end
    s_tvalid <= 1'b0;
    wait_cnt = 0;
    while (pending_results.size() != 0 && wait_cnt < 200000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (Depth + 10) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("** top_k_ranked_table_top: PASSED **");
    end else begin
      $display("** top_k_ranked_table_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> top_k_ranked_table_top.f
+incdir+sv
sv/tkrt_pkg.sv
sv/tkrt_ram.sv
sv/top_k_ranked_table_top.sv
sv/tkrt_checker.sv
tb/top_k_ranked_table_top_tb.sv
